[src/imh_pkg.sv]
// Package for the indexed max-heap block: field widths, operation and
// status codes, sequencer state type. No dependencies.
package imh_pkg;

    localparam int KIND_W   = 2;
    localparam int HANDLE_W = 10;
    localparam int KEY_W    = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 11;

    localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADJUST = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DUP     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_ABSENT  = 3'd4;

    localparam logic [COUNT_W-1:0] CAP_LIMIT_RESET = 11'd1024;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_PLACE,
        S_FINISH
    } state_t;

endpackage

[src/imh_if.sv]
// Channel interfaces of the indexed max-heap: request, response, config.
// Depends on imh_pkg.
interface imh_req_if;
    logic                          valid;
    logic                          ready;
    logic [imh_pkg::KIND_W-1:0]    kind;
    logic [imh_pkg::HANDLE_W-1:0]  handle;
    logic [imh_pkg::KEY_W-1:0]     key;
    modport source (output valid, kind, handle, key, input ready);
    modport sink   (input valid, kind, handle, key, output ready);
endinterface

interface imh_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [imh_pkg::STATUS_W-1:0]  status;
    logic [imh_pkg::HANDLE_W-1:0]  out_handle;
    logic [imh_pkg::KEY_W-1:0]     out_key;
    logic [imh_pkg::COUNT_W-1:0]   count;
    logic                          is_empty;
    logic                          is_full;
    modport source (output valid, status, out_handle, out_key, count, is_empty, is_full,
                    input ready);
    modport sink   (input valid, status, out_handle, out_key, count, is_empty, is_full,
                    output ready);
endinterface

interface imh_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [imh_pkg::COUNT_W-1:0]   data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[src/indexed_max_heap.sv]
// Indexed binary max-heap top level: sequencer, compare unit, memories.
// Depends on imh_pkg, imh_if, imh_ram, imh_slot_ram.
//
// One transaction at a time. After reset the block sweeps all HANDLE_COUNT
// entries of the presence memory (1024 by default) before accepting any
// request; config writes are taken throughout. A request that fails, a
// no-op and a pop of the last entry go from the lookup state straight to
// the finish state. A pop that sifts walks down from the root; a push or
// adjust walks up and then down, and every walk ends in the place state.
// The finished result may wait in the finish state for the output register
// to free up. The pace is set by the single slot memory, read in the read
// state of each level and compared and written in its compare state. A
// result waits in the output register while the next request is already
// taken.
module indexed_max_heap #(
    parameter int CAPACITY     = 1024,
    parameter int HANDLE_COUNT = 1024,
    parameter int KEY_BITS     = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    imh_req_if.sink   req,
    imh_rsp_if.source rsp,
    imh_cfg_if.sink   cfg
);
    import imh_pkg::*;

    localparam int PW = $clog2(CAPACITY);
    localparam int HW = $clog2(HANDLE_COUNT);
    localparam int KW = KEY_BITS;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = HW + KW;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0] cap_reg;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [PW-1:0]      p_reg, p_next;
    logic [HW-1:0]      eh_reg, eh_next;
    logic [KW-1:0]      ek_reg, ek_next;
    logic [HW-1:0]      clr_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic               hvalid_reg;
    logic [HW-1:0]      hidx_reg;
    logic [KW-1:0]      key_reg;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [HW-1:0]      oh_reg, oh_next;
    logic [KW-1:0]      ok_reg, ok_next;
    logic               out_valid_reg;
    logic [STATUS_W-1:0] rs_status_reg;
    logic [HANDLE_W-1:0] rs_handle_reg;
    logic [KEY_W-1:0]   rs_key_reg;
    logic [COUNT_W-1:0] rs_count_reg;
    logic               rs_empty_reg, rs_full_reg;

    logic          slot_we, pos_we, pres_we, pres_wd;
    logic [PW-1:0] slot_wa, slot_ra, slot_rb, pos_wd, pos_rd;
    logic [SW-1:0] slot_wd, slot_da, slot_db;
    logic [HW-1:0] pos_wa, pos_ra, pres_wa, pres_ra;
    logic [0:0]    pres_rd;

    logic          accept, finish_load;
    logic [31:0]   lim32, left32, right32, handle32;
    logic [63:0]   key64;
    logic          at_limit, hvalid_in;
    logic [PW-1:0] parent;
    logic [HW-1:0] a_h, b_h, best_h;
    logic [KW-1:0] a_k, b_k, best_k;
    logic          use_right;
    logic [PW-1:0] best_p;

    imh_slot_ram #(.DEPTH(CAPACITY), .WIDTH(SW)) u_slots (
        .clk(clk), .we(slot_we), .waddr(slot_wa), .wdata(slot_wd),
        .raddr_a(slot_ra), .rdata_a(slot_da), .raddr_b(slot_rb), .rdata_b(slot_db)
    );

    imh_ram #(.DEPTH(HANDLE_COUNT), .WIDTH(PW)) u_pos (
        .clk(clk), .we(pos_we), .waddr(pos_wa), .wdata(pos_wd),
        .raddr(pos_ra), .rdata(pos_rd)
    );

    imh_ram #(.DEPTH(HANDLE_COUNT), .WIDTH(1)) u_pres (
        .clk(clk), .we(pres_we), .waddr(pres_wa), .wdata(pres_wd),
        .raddr(pres_ra), .rdata(pres_rd)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign lim32    = (32'(cap_reg) < 32'(CAPACITY)) ? 32'(cap_reg) : 32'(CAPACITY);
    assign at_limit = 32'(cnt_reg) >= lim32;
    assign handle32 = 32'(req.handle);
    assign hvalid_in = handle32 < 32'(HANDLE_COUNT);
    assign key64    = 64'(req.key);

    assign parent  = (p_reg - 1'b1) >> 1;
    assign left32  = (32'(p_reg) << 1) + 32'd1;
    assign right32 = left32 + 32'd1;

    // shared compare unit
    assign a_h = slot_da[SW-1:KW];
    assign a_k = slot_da[KW-1:0];
    assign b_h = slot_db[SW-1:KW];
    assign b_k = slot_db[KW-1:0];
    assign use_right = (right32 < 32'(cnt_reg)) && (b_k > a_k);
    assign best_h = use_right ? b_h : a_h;
    assign best_k = use_right ? b_k : a_k;
    assign best_p = use_right ? right32[PW-1:0] : left32[PW-1:0];

    assign finish_load = (state_reg == S_FINISH) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == HW'(HANDLE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_FINISH;
                priority case (kind_reg)
                    KIND_PUSH:
                    begin
                        if (hvalid_reg && !pres_rd[0] && !at_limit)
                        begin
                            state_next = S_UP_RD;
                        end
                    end
                    KIND_POP:
                    begin
                        if (cnt_reg > CW'(1))
                        begin
                            state_next = S_DN_RD;
                        end
                    end
                    KIND_ADJUST:
                    begin
                        if (hvalid_reg && pres_rd[0])
                        begin
                            state_next = S_UP_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_UP_RD:
            begin
                state_next = (p_reg == '0) ? S_DN_RD : S_UP_CMP;
            end
            S_UP_CMP:
            begin
                state_next = (a_k < ek_reg) ? S_UP_RD : S_DN_RD;
            end
            S_DN_RD:
            begin
                state_next = (left32 >= 32'(cnt_reg)) ? S_PLACE : S_DN_CMP;
            end
            S_DN_CMP:
            begin
                state_next = (best_k > ek_reg) ? S_DN_RD : S_PLACE;
            end
            S_PLACE:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (finish_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        slot_we = 1'b0;
        slot_wa = p_reg;
        slot_wd = {eh_reg, ek_reg};
        slot_ra = parent;
        slot_rb = right32[PW-1:0];
        pos_we  = 1'b0;
        pos_wa  = eh_reg;
        pos_wd  = p_reg;
        pos_ra  = handle32[HW-1:0];
        pres_we = 1'b0;
        pres_wa = hidx_reg;
        pres_wd = 1'b0;
        pres_ra = handle32[HW-1:0];
        cnt_next = cnt_reg;
        p_next   = p_reg;
        eh_next  = eh_reg;
        ek_next  = ek_reg;
        st_next  = st_reg;
        oh_next  = oh_reg;
        ok_next  = ok_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                pres_we = 1'b1;
                pres_wa = clr_reg;
            end
            S_IDLE:
            begin
                slot_ra = '0;
                slot_rb = PW'(cnt_reg - 1'b1);
                st_next = STAT_OK;
                oh_next = '0;
                ok_next = '0;
            end
            S_LOOKUP:
            begin
                priority case (kind_reg)
                    KIND_PUSH:
                    begin
                        if (!hvalid_reg)
                        begin
                            st_next = STAT_ABSENT;
                        end
                        else if (pres_rd[0])
                        begin
                            st_next = STAT_DUP;
                        end
                        else if (at_limit)
                        begin
                            st_next = STAT_FULL;
                        end
                        else
                        begin
                            pres_we  = 1'b1;
                            pres_wd  = 1'b1;
                            eh_next  = hidx_reg;
                            ek_next  = key_reg;
                            p_next   = cnt_reg[PW-1:0];
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    KIND_POP:
                    begin
                        if (cnt_reg == '0)
                        begin
                            st_next = STAT_EMPTY;
                        end
                        else
                        begin
                            oh_next  = a_h;
                            ok_next  = a_k;
                            pres_we  = 1'b1;
                            pres_wa  = a_h;
                            cnt_next = cnt_reg - 1'b1;
                            eh_next  = b_h;
                            ek_next  = b_k;
                            p_next   = '0;
                        end
                    end
                    KIND_ADJUST:
                    begin
                        if (!hvalid_reg || !pres_rd[0])
                        begin
                            st_next = STAT_ABSENT;
                        end
                        else
                        begin
                            eh_next = hidx_reg;
                            ek_next = key_reg;
                            p_next  = pos_rd;
                        end
                    end
                    default:
                    begin
                        st_next = STAT_OK;
                    end
                endcase
            end
            S_UP_RD:
            begin
                slot_ra = parent;
            end
            S_UP_CMP:
            begin
                if (a_k < ek_reg)
                begin
                    slot_we = 1'b1;
                    slot_wd = slot_da;
                    pos_we  = 1'b1;
                    pos_wa  = a_h;
                    p_next  = parent;
                end
            end
            S_DN_RD:
            begin
                slot_ra = left32[PW-1:0];
                slot_rb = right32[PW-1:0];
            end
            S_DN_CMP:
            begin
                if (best_k > ek_reg)
                begin
                    slot_we = 1'b1;
                    slot_wd = {best_h, best_k};
                    pos_we  = 1'b1;
                    pos_wa  = best_h;
                    p_next  = best_p;
                end
            end
            S_PLACE:
            begin
                slot_we = 1'b1;
                pos_we  = 1'b1;
            end
            S_FINISH:
            begin
                slot_we = 1'b0;
            end
            default:
            begin
                slot_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            cap_reg       <= CAP_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg.valid)
            begin
                cap_reg <= cfg.data;
            end
            if (finish_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg  <= p_next;
        eh_reg <= eh_next;
        ek_reg <= ek_next;
        st_reg <= st_next;
        oh_reg <= oh_next;
        ok_reg <= ok_next;
        if (accept)
        begin
            kind_reg   <= req.kind;
            hvalid_reg <= hvalid_in;
            hidx_reg   <= handle32[HW-1:0];
            key_reg    <= key64[KW-1:0];
        end
        if (finish_load)
        begin
            rs_status_reg <= st_reg;
            rs_handle_reg <= HANDLE_W'(32'(oh_reg));
            rs_key_reg    <= KEY_W'(64'(ok_reg));
            rs_count_reg  <= COUNT_W'(32'(cnt_reg));
            rs_empty_reg  <= (cnt_reg == '0);
            rs_full_reg   <= at_limit;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = rs_status_reg;
    assign rsp.out_handle = rs_handle_reg;
    assign rsp.out_key    = rs_key_reg;
    assign rsp.count      = rs_count_reg;
    assign rsp.is_empty   = rs_empty_reg;
    assign rsp.is_full    = rs_full_reg;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= 32'(CAPACITY))
        else $error("heap count above capacity");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.is_empty == (rsp.count == '0)))
        else $error("empty flag disagrees with count");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !req.ready)
        else $error("request taken during presence sweep");
`endif
endmodule

[src/imh_ram.sv]
// Simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module imh_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[src/imh_slot_ram.sv]
// Heap slot RAM: one write port, two registered read ports (both children).
// No dependencies.
module imh_slot_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 26
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule
